### rtl/core/blp_pkg.sv
// Package for the breathing LED PWM block: item codes, phase codes, engine state.
// No dependencies; used by blp_engine and breathing_led_pwm.
`timescale 1ns / 1ps

package blp_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // PWM period phases
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_HOLD  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_STEP  = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_PERIOD_TICKS = 2'd0;
    localparam logic [1:0] CFG_DUTY_STEP    = 2'd1;
    localparam logic [1:0] CFG_DUTY_MAX     = 2'd2;

    localparam logic [7:0] PERIOD_TICKS_RST = 8'd20;
    localparam logic [6:0] DUTY_STEP_RST    = 7'd1;
    localparam logic [6:0] DUTY_MAX_RST     = 7'd20;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  duty_level;
        logic        rising;
        logic        running;
        logic [7:0]  tick_count;
        logic        led_level;
    } eng_state_t;

    typedef struct packed {
        logic [7:0] period_ticks;
        logic [6:0] duty_step;
        logic [6:0] duty_max;
    } eng_cfg_t;

endpackage

### rtl/core/breathing_led_pwm.sv
// Top level of the breathing LED PWM heartbeat: stream ports, config registers,
// input beat register, engine state and result register. Depends on blp_pkg, blp_engine.
`timescale 1ns / 1ps

// Path: an accepted input beat goes through the input beat register, then the result register, onto m_.
// Throughput: one beat per cycle; both stages advance together whenever the
//   result register is empty or being drained, so backpressure only stalls.
// Reset (aresetn low, synchronous): pipeline emptied, engine state to period
//   start, duty 0, ramp rising, running, LED off; registers to 20 / 1 / 20.
module breathing_led_pwm import blp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] tick, [7:1] zero
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [0] led_on, [7:1] duty_now, [8] ramp_rising, [15:9] zero
);

    eng_cfg_t   cfg_reg;
    eng_state_t st_reg;
    eng_state_t st_next;

    // input stage
    logic   in_vld_reg;
    mode_t  in_mode_reg;
    logic   in_tick_reg;

    // result stage
    logic        out_vld_reg;
    logic        out_led_reg;
    logic [6:0]  out_duty_reg;
    logic        out_rise_reg;

    logic adv;      // result stage can take a new beat
    logic fire;     // input stage beat moves through the engine

    assign adv      = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;

    blp_engine u_engine (
        .cur  (st_reg),
        .cfg  (cfg_reg),
        .mode (in_mode_reg),
        .tick (in_tick_reg),
        .nxt  (st_next)
    );

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_ticks <= PERIOD_TICKS_RST;
            cfg_reg.duty_step    <= DUTY_STEP_RST;
            cfg_reg.duty_max     <= DUTY_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PERIOD_TICKS: cfg_reg.period_ticks <= cfg_data;
                CFG_DUTY_STEP:    cfg_reg.duty_step    <= cfg_data[6:0];
                CFG_DUTY_MAX:     cfg_reg.duty_max     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= mode_t'(s_tuser);
            in_tick_reg <= s_tdata[0];
        end
    end

    // engine state, updated once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase      <= PH_START;
            st_reg.duty_level <= 7'd0;
            st_reg.rising     <= 1'b1;
            st_reg.running    <= 1'b1;
            st_reg.tick_count <= 8'd0;
            st_reg.led_level  <= 1'b0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_led_reg  <= st_next.led_level;
            out_duty_reg <= st_next.duty_level;
            out_rise_reg <= st_next.rising;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_rise_reg, out_duty_reg, out_led_reg};

endmodule

### rtl/core/blp_engine.sv
// Next-state logic of the PWM engine for one item (run, start, stop).
// Depends on blp_pkg.
`timescale 1ns / 1ps

module blp_engine import blp_pkg::*; (
    input  eng_state_t cur,
    input  eng_cfg_t   cfg,
    input  mode_t      mode,
    input  logic       tick,
    output eng_state_t nxt
);

    logic [7:0] tc_inc;
    logic [7:0] ramp_sum;

    assign ramp_sum = {1'b0, cur.duty_level} + {1'b0, cfg.duty_step};

    always_comb begin
        nxt    = cur;
        tc_inc = cur.tick_count;
        // saturating tick count
        if (tick && (cur.tick_count != 8'hFF)) begin
            tc_inc = cur.tick_count + 8'd1;
        end
        unique case (mode)
            MODE_RUN: begin
                nxt.tick_count = tc_inc;
                unique case (cur.phase)
                    PH_START: begin
                        if (!cur.running) begin
                            nxt.led_level = 1'b0;
                        end else begin
                            if (cur.duty_level != 7'd0) begin
                                nxt.led_level = 1'b1;
                            end
                            nxt.tick_count = 8'd0;
                            nxt.phase      = PH_HOLD;
                        end
                    end
                    PH_HOLD: begin
                        if (tc_inc >= {1'b0, cur.duty_level}) begin
                            nxt.led_level = 1'b0;
                            nxt.phase     = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (tc_inc >= cfg.period_ticks) begin
                            nxt.phase = PH_STEP;
                        end
                    end
                    PH_STEP: begin
                        // triangle ramp: clamp at peak, floor at zero
                        if (cur.rising) begin
                            if (ramp_sum >= {1'b0, cfg.duty_max}) begin
                                nxt.duty_level = cfg.duty_max;
                                nxt.rising     = 1'b0;
                            end else begin
                                nxt.duty_level = ramp_sum[6:0];
                            end
                        end else begin
                            if (cur.duty_level <= cfg.duty_step) begin
                                nxt.duty_level = 7'd0;
                                nxt.rising     = 1'b1;
                            end else begin
                                nxt.duty_level = cur.duty_level - cfg.duty_step;
                            end
                        end
                        nxt.phase = PH_START;
                    end
                    default: nxt = cur;
                endcase
            end
            MODE_START: begin
                nxt.running = 1'b1;
            end
            MODE_STOP: begin
                // phase is kept
                nxt.running    = 1'b0;
                nxt.led_level  = 1'b0;
                nxt.duty_level = 7'd0;
                nxt.rising     = 1'b1;
            end
            default: nxt = cur;
        endcase
    end

endmodule

### tb/breathing_led_pwm_tb.sv
// Self-checking bench for breathing_led_pwm: stream stimulus, random stalls, register
// phases, and a ramp tracker that predicts every result beat. Depends on blp_pkg.
`timescale 1ns / 1ps

import blp_pkg::*;

// Predicts the engine and holds the result beats still owed by the block.
class led_ramp_tracker;
    typedef struct packed {
        logic [6:0] pad;
        logic       rising;
        logic [6:0] duty;
        logic       led;
    } result_beat_t;

    // engine copy
    phase_t     ph;
    logic [6:0] duty;
    bit         rising;
    bit         running;
    logic [7:0] ticks;
    bit         led;
    // register copy
    logic [7:0] period;
    logic [6:0] step;
    logic [6:0] peak;

    result_beat_t expected_beats[$];
    int errors;
    int beats_checked;
    int peaks_hit;
    int mode_hits[4];

    function new();
        ph      = PH_START;
        duty    = '0;
        rising  = 1'b1;
        running = 1'b1;
        ticks   = '0;
        led     = 1'b0;
        period  = PERIOD_TICKS_RST;
        step    = DUTY_STEP_RST;
        peak    = DUTY_MAX_RST;
        errors  = 0;
        beats_checked = 0;
        peaks_hit = 0;
        foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
        case (idx)
            CFG_PERIOD_TICKS: period = val;
            CFG_DUTY_STEP:    step   = val[6:0];
            CFG_DUTY_MAX:     peak   = val[6:0];
            default: ;
        endcase
    endfunction

    // one period's duty step; clamps at the peak and bottoms out at zero
    function void step_ramp();
        logic [7:0] sum;
        if (rising) begin
            sum = {1'b0, duty} + {1'b0, step};
            if (sum >= {1'b0, peak}) begin
                duty   = peak;
                rising = 1'b0;
                peaks_hit++;
            end else begin
                duty = sum[6:0];
            end
        end else if (duty <= step) begin
            duty   = '0;
            rising = 1'b1;
        end else begin
            duty = duty - step;
        end
    endfunction

    function void advance_engine(logic tk);
        if (tk && ticks != 8'hFF)
            ticks++;
        case (ph)
            PH_START: begin
                if (!running) begin
                    led = 1'b0;
                end else begin
                    if (duty != 0)
                        led = 1'b1;
                    ticks = '0;
                    ph    = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (ticks >= {1'b0, duty}) begin
                    led = 1'b0;
                    ph  = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (ticks >= period)
                    ph = PH_STEP;
            end
            default: begin
                step_ramp();
                ph = PH_START;
            end
        endcase
    endfunction

    // called on every accepted input beat
    function void note_item(mode_t md, logic tk);
        result_beat_t b;
        mode_hits[md]++;
        case (md)
            MODE_RUN:   advance_engine(tk);
            MODE_START: running = 1'b1;
            MODE_STOP: begin
                running = 1'b0;
                led     = 1'b0;
                duty    = '0;
                rising  = 1'b1;
            end
            default: ;
        endcase
        b.pad    = '0;
        b.rising = rising;
        b.duty   = duty;
        b.led    = led;
        expected_beats.push_back(b);
    endfunction

    function void check_beat(logic [15:0] data);
        result_beat_t got;
        result_beat_t want;
        got = data;
        if (expected_beats.size() == 0) begin
            $error("unexpected result beat 0x%04h", data);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.led !== want.led) begin
            $error("led_on: expected %0d, got %0d", want.led, got.led);
            errors++;
        end
        if (got.duty !== want.duty) begin
            $error("duty_now: expected %0d, got %0d", want.duty, got.duty);
            errors++;
        end
        if (got.rising !== want.rising) begin
            $error("ramp_rising: expected %0d, got %0d", want.rising, got.rising);
            errors++;
        end
        if (got.pad !== want.pad) begin
            $error("m_tdata pad: expected %0d, got %0d", want.pad, got.pad);
            errors++;
        end
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction
endclass

module breathing_led_pwm_tb;

    // idle cycles with no beat on either side before the run is declared hung;
    // worst legit gap is the HOLD_LEN receiver hold plus the pipeline drain
    localparam int IDLE_LIMIT = 1000;
    // result beat index at which the receiver parks for a long stretch
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 64;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [0] tick, [7:1] zero
    logic [1:0]  s_tuser;     // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [0] led_on, [7:1] duty_now, [8] ramp_rising, [15:9] zero

    led_ramp_tracker tracker;

    // set per register phase; when high neither side inserts idle cycles
    bit no_gaps;
    int settings_run;
    bit hold_done;

    breathing_led_pwm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sender side. Every task is entered and left right after a falling
    // edge; s_tvalid is only touched once per falling edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input mode_t md, input logic tk);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {7'b0, tk};
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(md, tk);
        @(negedge aclk);
    endtask

    // mostly run steps so periods actually complete; start/stop/unused sprinkled in
    task automatic send_random(input int n);
        int    r;
        mode_t md;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 88)      md = MODE_RUN;
            else if (r < 93) md = MODE_START;
            else if (r < 96) md = MODE_STOP;
            else             md = MODE_NONE;
            send_beat(md, $urandom_range(0, 99) < 75);
        end
    endtask

    // drop valid, let every owed result come back; registers only move after this
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one write per call, enable dropped again before the next one
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [7:0] per, input logic [6:0] stp, input logic [6:0] mx);
        write_reg(CFG_PERIOD_TICKS, per);
        write_reg(CFG_DUTY_STEP, {1'b0, stp});
        write_reg(CFG_DUTY_MAX, {1'b0, mx});
        settings_run++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per beat, one long hold-off so the pipeline
    // fills and s_tready has to drop.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        int taken;
        m_tready  = 1'b0;
        taken     = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (taken == HOLD_AT && !hold_done) begin
                gap       = HOLD_LEN;
                hold_done = 1'b1;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_beat(m_tdata);
            taken++;
            @(negedge aclk);
        end
    end

    // Watchdog: counts cycles with no beat on either channel
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker      = new();
        no_gaps      = 1'b0;
        settings_run = 0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_RUN;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: short period, step that overshoots a small peak so a
        // whole ramp turn fits in a couple dozen beats.
        set_regs(8'd1, 7'd3, 7'd4);
        send_beat(MODE_NONE, 1'b0);     // unused code, reports reset state
        send_beat(MODE_NONE, 1'b1);
        send_beat(MODE_RUN, 1'b0);      // period start with zero duty: LED untouched
        send_beat(MODE_RUN, 1'b1);      // hold ends at once
        send_beat(MODE_RUN, 1'b1);      // wait ends (period 1)
        send_beat(MODE_RUN, 1'b0);      // ramp up 0 -> 3
        send_beat(MODE_RUN, 1'b0);      // LED on
        repeat (3) send_beat(MODE_RUN, 1'b1);
        send_beat(MODE_RUN, 1'b0);
        send_beat(MODE_RUN, 1'b1);      // 3 + 3 overshoots peak 4: clamp, turn down
        send_beat(MODE_RUN, 1'b0);
        send_beat(MODE_STOP, 1'b1);     // stop mid-hold, tick ignored
        send_beat(MODE_RUN, 1'b0);      // stopped, but hold still proceeds
        send_beat(MODE_RUN, 1'b1);
        send_beat(MODE_RUN, 1'b1);      // ramp step while stopped
        send_beat(MODE_RUN, 1'b1);      // stopped at period start: LED forced off
        send_beat(MODE_START, 1'b1);
        send_beat(MODE_RUN, 1'b0);
        repeat (3) send_beat(MODE_RUN, 1'b1);
        send_beat(MODE_RUN, 1'b1);
        send_beat(MODE_RUN, 1'b0);
        drain();

        // Reset-value registers
        set_regs(PERIOD_TICKS_RST, DUTY_STEP_RST, DUTY_MAX_RST);
        send_random(150);
        drain();

        // Low extremes, back-to-back on both sides
        no_gaps = 1'b1;
        set_regs(8'd1, 7'd1, 7'd1);
        send_random(120);
        drain();
        no_gaps = 1'b0;

        // High extremes; a long stopped stretch of ticks drives the tick
        // counter into saturation before the engine is restarted.
        set_regs(8'd255, 7'd127, 7'd127);
        send_beat(MODE_STOP, 1'b0);
        repeat (300) send_beat(MODE_RUN, 1'b1);
        send_beat(MODE_START, 1'b0);
        send_random(60);
        drain();

        // Mid-range ramp settings
        set_regs(8'd3, 7'd5, 7'd40);
        send_random(150);
        drain();

        // Random registers, short periods so the ramp keeps moving
        set_regs(8'($urandom_range(1, 6)), 7'($urandom_range(1, 127)),
                 7'($urandom_range(1, 127)));
        send_random(150);
        drain();

        // let any stray beat surface before the verdict
        repeat (10) @(posedge aclk);

        $display("Covered %0d result beats over %0d register settings, %0d ramp peaks.",
                 tracker.beats_checked, settings_run, tracker.peaks_hit);
        $display("Beats by mode: run %0d, start %0d, stop %0d, unused %0d.",
                 tracker.mode_hits[MODE_RUN], tracker.mode_hits[MODE_START],
                 tracker.mode_hits[MODE_STOP], tracker.mode_hits[MODE_NONE]);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
